@@ hw/rtl/ira_pkg.sv @@
// ira_pkg: types, constants and helper functions of the radix-to-ascii converter
// no dependencies; imported by every module under hw/rtl

package ira_pkg;

  // width of the signed input value
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned RADIX_WIDTH = 6;
  localparam int unsigned CHAR_WIDTH  = 8;

  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = RADIX_WIDTH'(36);

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2d;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [RADIX_WIDTH-1:0] DEC_DIGITS  = RADIX_WIDTH'(10);

  // the divider consumes one byte of the dividend per cycle
  localparam int unsigned CHUNK      = 8;
  localparam int unsigned NCHUNK     = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
  localparam int unsigned PAD_WIDTH  = NCHUNK * CHUNK;
  localparam int unsigned CIDX_WIDTH = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  // digit stack: at most one digit per value bit (base 2)
  localparam int unsigned MAX_DIGITS = VALUE_WIDTH;
  localparam int unsigned SIDX_WIDTH = $clog2(MAX_DIGITS);
  localparam int unsigned SP_WIDTH   = $clog2(MAX_DIGITS + 1);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic        [RADIX_WIDTH-1:0] radix;
  } ira_in_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] out_char;
    logic                  last;
  } ira_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } ira_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic chunk_last;
    logic quot_zero;
    logic neg;
    logic last_digit;
  } ira_sts_t;

  // index of the highest nonzero byte, zero when the word is zero
  function automatic logic [CIDX_WIDTH-1:0] top_chunk(logic [PAD_WIDTH-1:0] m);
    logic [CIDX_WIDTH-1:0] t;
    t = '0;
    for (int k = 0; k < NCHUNK; k++) begin
      if (m[k*CHUNK +: CHUNK] != '0) t = CIDX_WIDTH'(k);
    end
    return t;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] digit_char(logic [RADIX_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      c = CHAR_LOWER_A + CHAR_WIDTH'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/integer_to_radix_ascii.sv @@
// integer_to_radix_ascii: top level over ira_pkg, ira_ctrl and ira_dpath, base 2..36 text
// sequence: load at accept, then per digit one pass down from the highest nonzero byte
//   of the running quotient to byte zero, then the characters ('-' then msd first)
// one beat in flight: busy stays high until the last character of a beat is issued
// results come out on consecutive cycles, one per strobe; the receiver cannot stall
// reset: async active low, clears the state machine, digit count and strobe

module integer_to_radix_ascii
  import ira_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  // command side: a beat is taken when start is high and busy is low
  input  logic     start,
  output logic     busy,
  input  ira_in_t  item_i,
  // result side: one character per strobe, last marks the end of the string
  output logic     strobe_o,
  output ira_out_t result_o
);

  ira_cmd_t cmd;
  ira_sts_t sts;

  // controller: idle -> divide (one byte per cycle) -> optional sign -> emit
  ira_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath: magnitude register divided in place, remainders pushed on a
  // digit stack and popped in reverse order into the output register
  ira_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

endmodule

@@ hw/rtl/ira_ctrl.sv @@
// ira_ctrl: sequencing state machine of the radix-to-ascii converter
// depends on ira_pkg; drives ira_dpath through ira_cmd_t / ira_sts_t

module ira_ctrl
  import ira_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ira_sts_t sts_i,
  output ira_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } ira_state_e;

  ira_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        // digit finished and nothing left to divide
        if (sts_i.chunk_last && sts_i.quot_zero) begin
          state_d = sts_i.neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit_digit = 1'b1;
        if (sts_i.last_digit) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

@@ hw/rtl/ira_dpath.sv @@
// ira_dpath: byte-serial divider, digit stack and output register
// depends on ira_pkg; controlled by ira_ctrl

module ira_dpath
  import ira_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ira_in_t  item_i,
  input  ira_cmd_t cmd_i,
  output ira_sts_t sts_o,
  output logic     strobe_o,
  output ira_out_t result_o
);

  logic [PAD_WIDTH-1:0]   mag_q, mag_d, mag_next;
  logic [RADIX_WIDTH-1:0] rem_q, rem_d, rem_w;
  logic [RADIX_WIDTH-1:0] base_q, base_d;
  logic                   neg_q, neg_d;
  logic [CIDX_WIDTH-1:0]  idx_q, idx_d;
  logic [SP_WIDTH-1:0]    sp_q, sp_d, sp_m1;
  logic [RADIX_WIDTH-1:0] stack_q [MAX_DIGITS];
  logic                   strobe_q, strobe_d;
  ira_out_t               res_q, res_d;

  logic [VALUE_WIDTH-1:0] v_in, v_mag;
  logic [RADIX_WIDTH-1:0] radix_sat;
  logic [CHUNK-1:0]       chunk, qbits;
  logic [RADIX_WIDTH:0]   trial;

  // magnitude and clamped base of a new beat
  assign v_in  = item_i.value;
  assign v_mag = v_in[VALUE_WIDTH-1] ? (~v_in + VALUE_WIDTH'(1)) : v_in;

  always_comb begin
    if (item_i.radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (item_i.radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = item_i.radix;
    end
  end

  // eight restoring division steps on the selected byte
  assign chunk = mag_q[idx_q*CHUNK +: CHUNK];

  always_comb begin
    rem_w = rem_q;
    trial = '0;
    qbits = '0;
    for (int b = CHUNK - 1; b >= 0; b--) begin
      trial = {rem_w, chunk[b]};
      if (trial >= {1'b0, base_q}) begin
        trial    = trial - {1'b0, base_q};
        qbits[b] = 1'b1;
      end
      rem_w = trial[RADIX_WIDTH-1:0];
    end
  end

  always_comb begin
    mag_next = mag_q;
    mag_next[idx_q*CHUNK +: CHUNK] = qbits;
  end

  assign sp_m1 = sp_q - SP_WIDTH'(1);

  always_comb begin
    mag_d    = mag_q;
    rem_d    = rem_q;
    base_d   = base_q;
    neg_d    = neg_q;
    idx_d    = idx_q;
    sp_d     = sp_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    if (cmd_i.load) begin
      mag_d  = PAD_WIDTH'(v_mag);
      rem_d  = '0;
      base_d = radix_sat;
      neg_d  = v_in[VALUE_WIDTH-1];
      idx_d  = top_chunk(PAD_WIDTH'(v_mag));
      sp_d   = '0;
    end
    if (cmd_i.div_step) begin
      mag_d = mag_next;
      if (idx_q == '0) begin
        // digit done: restart from the top byte of the quotient
        rem_d = '0;
        idx_d = top_chunk(mag_next);
        sp_d  = sp_q + SP_WIDTH'(1);
      end else begin
        rem_d = rem_w;
        idx_d = idx_q - CIDX_WIDTH'(1);
      end
    end
    if (cmd_i.emit_sign) begin
      strobe_d       = 1'b1;
      res_d.out_char = CHAR_MINUS;
      res_d.last     = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      strobe_d       = 1'b1;
      res_d.out_char = digit_char(stack_q[sp_m1[SIDX_WIDTH-1:0]]);
      res_d.last     = (sp_q == SP_WIDTH'(1));
      sp_d           = sp_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      sp_q     <= sp_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    neg_q  <= neg_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    if (cmd_i.div_step && (idx_q == '0)) begin
      stack_q[sp_q[SIDX_WIDTH-1:0]] <= rem_w;
    end
  end

  assign sts_o.chunk_last = (idx_q == '0);
  assign sts_o.quot_zero  = (mag_next == '0);
  assign sts_o.neg        = neg_q;
  assign sts_o.last_digit = (sp_q == SP_WIDTH'(1));

  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

@@ hw/rtl/ira_checker.sv @@
// ira_checker: port-level assertions for integer_to_radix_ascii, bound to the top
// depends on ira_pkg

module ira_checker
  import ira_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     strobe_o,
  input ira_out_t result_o
);

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // no character right after an accept
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !strobe_o)
    else $error("strobe right after accept");

  // characters of one string are back to back
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !result_o.last) |=> strobe_o)
    else $error("gap inside a string");

  // the final character is not directly followed by another strobe
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.last) |=> !strobe_o)
    else $error("strobe after last character");

  // the sign is never the final character
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (result_o.out_char == CHAR_MINUS)) |-> !result_o.last)
    else $error("sign marked last");

endmodule

bind integer_to_radix_ascii ira_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o),
  .result_o (result_o)
);
